// ===== design/sha1_pkg.sv =====
// Shared types and constants for the SHA-1 digest block.
package sha1_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_item_type;

   // Byte command passed from the front part to the compression engine.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } eng_state_type;

   localparam logic [31:0] H_INIT0 = 32'h67452301;
   localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
   localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
   localparam logic [31:0] H_INIT3 = 32'h10325476;
   localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [6:0]  ROUNDS = 7'd80;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

endpackage

// ===== design/sha1_queue.sv =====
// Short item queue between the input side and the compression engine.
module sha1_queue
   import sha1_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_take,
   output cmd_type out_cmd
);
   cmd_type     mem_ff [4];
   logic [1:0]  wr_ff, rd_ff;
   logic [2:0]  cnt_ff;
   logic        push, pop;

   assign in_stall  = (cnt_ff == 3'd4);
   assign out_valid = (cnt_ff != 3'd0);
   assign out_cmd   = mem_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && out_take;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_cmd;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop)  rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'b0, push} - {2'b0, pop};
      end
   end
endmodule

// ===== design/sha1_engine.sv =====
// Block packing, padding, 80-round compression and digest output.
module sha1_engine
   import sha1_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   output logic         cmd_take,
   input  cmd_type      cmd,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);
   eng_state_type state_ff, state_in;
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [63:0] len_ff;
   logic [5:0]  pos_ff;
   logic [6:0]  rnd_ff;
   logic        fin_ff;   // compressing the final block of a message
   logic        lenblk_ff; // padding must end with a length-only block
   logic [2:0]  idx_ff;
   logic        pend_end_ff;

   logic [31:0] f, k, t, wnew;
   logic        start_rnd, put, put_last;
   logic [7:0]  put_byte;

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = K3;
      end
      t    = rotl(a_ff, 5) + f + e_ff + w_ff[0] + k;
      wnew = rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_take  = 1'b0;
      start_rnd = 1'b0;
      put       = 1'b0;
      put_last  = 1'b0;
      put_byte  = cmd.data_byte;
      case (state_ff)
         ST_IDLE: if (cmd_valid) begin
            cmd_take = 1'b1;
            if (cmd.byte_present) begin
               put = 1'b1;
               if (pos_ff == 6'd63) begin
                  start_rnd = 1'b1; state_in = ST_ROUND;
               end else if (cmd.message_end) state_in = ST_PAD;
            end else if (cmd.message_end) state_in = ST_PAD;
         end
         ST_PAD: begin
            // first pad step writes 0x80, then zeros; length lands at byte 56
            put = 1'b1;
            put_byte = lenblk_ff ? 8'h00 : PAD_BYTE;
            if (pos_ff == 6'd55 && lenblk_ff) begin
               put_last = 1'b1; start_rnd = 1'b1; state_in = ST_ROUND;
            end else if (pos_ff == 6'd63) begin
               start_rnd = 1'b1; state_in = ST_ROUND;
            end else if (pos_ff == 6'd55) begin
               put_last = 1'b1; start_rnd = 1'b1; state_in = ST_ROUND;
            end
         end
         ST_ROUND: if (rnd_ff == ROUNDS - 7'd1) state_in = ST_FOLD;
         ST_FOLD: begin
            if (fin_ff) state_in = ST_EMIT;
            else if (lenblk_ff || pend_end_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_EMIT: if (!rsp_stall && idx_ff == 3'd4) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = (state_ff == ST_EMIT);
   always_comb begin
      rsp_item.digest_word = h_ff[0];
      rsp_item.word_index  = idx_ff;
      rsp_item.last_word   = (idx_ff == 3'd4);
   end

   always_ff @(posedge clock) begin
      if (put) begin
         w_ff[pos_ff[5:2]] <= (pos_ff[1:0] == 2'd0)
            ? {put_byte, 24'h0}
            : (w_ff[pos_ff[5:2]] | ({24'h0, put_byte} << ((3 - pos_ff[1:0]) * 8)));
      end
      if (put_last) begin
         w_ff[14] <= len_ff[63:32];
         w_ff[15] <= len_ff[31:0];
      end
      if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wnew;
         e_ff <= d_ff; d_ff <= c_ff; c_ff <= rotl(b_ff, 30);
         b_ff <= a_ff; a_ff <= t;
      end
      if (start_rnd) begin
         a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
         d_ff <= h_ff[3]; e_ff <= h_ff[4];
      end
      if (reset) begin
         h_ff[0] <= H_INIT0; h_ff[1] <= H_INIT1; h_ff[2] <= H_INIT2;
         h_ff[3] <= H_INIT3; h_ff[4] <= H_INIT4;
         len_ff <= '0; pos_ff <= '0; rnd_ff <= '0;
         fin_ff <= 1'b0; lenblk_ff <= 1'b0; idx_ff <= '0;
      end else begin
         if (state_ff == ST_IDLE && cmd_valid && cmd.byte_present)
            len_ff <= len_ff + 64'd8;
         if (put) pos_ff <= pos_ff + 6'd1;
         if (put_last) pos_ff <= '0;
         if (start_rnd) rnd_ff <= '0;
         else if (state_ff == ST_ROUND) rnd_ff <= rnd_ff + 7'd1;
         if (state_ff == ST_IDLE && cmd_valid && cmd.message_end)
            lenblk_ff <= 1'b0;
         if (state_ff == ST_IDLE && cmd_valid)
            fin_ff <= 1'b0;
         if (state_ff == ST_PAD) begin
            lenblk_ff <= 1'b1;
            if (put_last) fin_ff <= 1'b1;
         end
         // a full data block on an end item still has to be padded
         if (state_ff == ST_IDLE && cmd_valid && cmd.message_end &&
             cmd.byte_present && pos_ff == 6'd63)
            fin_ff <= 1'b0;
         if (state_ff == ST_FOLD) begin
            h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
            h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
            h_ff[4] <= h_ff[4] + e_ff;
            idx_ff <= '0;
         end
         if (state_ff == ST_EMIT && !rsp_stall) begin
            idx_ff <= idx_ff + 3'd1;
            for (int i = 0; i < 4; i++) h_ff[i] <= h_ff[i + 1];
            h_ff[4] <= h_ff[0];
            if (idx_ff == 3'd4) begin
               h_ff[0] <= H_INIT0; h_ff[1] <= H_INIT1; h_ff[2] <= H_INIT2;
               h_ff[3] <= H_INIT3; h_ff[4] <= H_INIT4;
               len_ff <= '0; pos_ff <= '0; lenblk_ff <= 1'b0;
            end
         end
      end
   end

   // an end item whose byte filled a block resumes padding after the fold
   always_ff @(posedge clock) begin
      if (reset) pend_end_ff <= 1'b0;
      else if (state_ff == ST_IDLE && cmd_valid)
         pend_end_ff <= cmd.message_end && cmd.byte_present && pos_ff == 6'd63;
      else if (state_ff == ST_FOLD) pend_end_ff <= 1'b0;
   end
endmodule

// ===== design/sha1_message_digest.sv =====
// SHA-1 digest over a byte stream: item queue in front, compression engine behind.
// A byte that fills a block loads the working words, then runs 80 rounds and a fold;
// other bytes are only packed into the block. An end item adds one or two padded
// blocks, each of pad steps, 80 rounds and a fold, then five result items, one per
// cycle while rsp_stall is low. With its single round unit the engine takes no new
// bytes while it compresses a block.
// Synchronous reset restores the initial chaining words and empties the queue.
module sha1_message_digest
   import sha1_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);
   logic    q_valid, q_take;
   cmd_type q_cmd, in_cmd;

   always_comb begin
      in_cmd.data_byte    = req_item.data_byte;
      in_cmd.byte_present = req_item.byte_present;
      in_cmd.message_end  = req_item.message_end;
   end

   sha1_queue u_queue (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_take(q_take), .out_cmd(q_cmd)
   );

   sha1_engine u_engine (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
      .rsp_valid, .rsp_stall, .rsp_item
   );
endmodule
